### rtl/core/skvt_pkg.sv
package skvt_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int KEY_W        = 32;
	localparam int DATA_W       = 32;
	localparam int COUNT_W      = 5;
	localparam int CMD_W        = 2;
	localparam int STATUS_W     = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT    = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_FIRST  = 2'd2,
		CMD_NEXT   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	function automatic logic key_less(
		input logic [KEY_W-1:0] a,
		input logic [KEY_W-1:0] b,
		input logic             signed_keys
	);
		logic [KEY_W-1:0] flip;
		flip = {signed_keys, {(KEY_W-1){1'b0}}};
		return (a ^ flip) < (b ^ flip);
	endfunction

endpackage

### rtl/core/skvt_if.sv
interface skvt_cmd_if;
	import skvt_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [KEY_W-1:0]  key;
	logic [DATA_W-1:0] value;

	modport source (output valid, output command, output key, output value, input ready);
	modport sink   (input valid, input command, input key, input value, output ready);
endinterface

interface skvt_rsp_if;
	import skvt_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [KEY_W-1:0]    key_out;
	logic [DATA_W-1:0]   data_out;
	logic [COUNT_W-1:0]  count;

	modport source (
		output valid, output status, output found, output key_out, output data_out,
		output count, input ready
	);
	modport sink (
		input valid, input status, input found, input key_out, input data_out,
		input count, output ready
	);
endinterface

### rtl/core/skvt_ram.sv
module skvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/sorted_key_value_table_unit.sv
// Lookups and puts scan the key memory linearly through one shared comparator; an
// inserting put then moves each entry at or above its rank up one slot, and a result
// still waiting for the response handshake holds back the loading of the next.
// One item at a time: the next can be taken in the cycle after the result is loaded.
// Reset clears the count, the iterator and the handshakes, not the key and data memories.
module sorted_key_value_table_unit #(
	parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	skvt_cmd_if.sink   cmd,
	skvt_rsp_if.source rsp
);
	import skvt_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_HIT_RD,
		S_HIT_CMP,
		S_SH_RD,
		S_SH_WR,
		S_INS,
		S_ITER_RD,
		S_DONE
	} state_t;

	state_t              state_q;
	logic                signed_keys_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       iter_pos_q;
	logic                iter_valid_q;
	cmd_t                cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [DATA_W-1:0]   value_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       rank_q;
	logic                scan_vld_s1;
	status_t             status_q;
	logic                found_q;
	logic [KEY_W-1:0]    kout_q;
	logic [DATA_W-1:0]   dout_q;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic                rsp_found_q;
	logic [KEY_W-1:0]    rsp_key_q;
	logic [DATA_W-1:0]   rsp_data_q;
	logic [COUNT_W-1:0]  rsp_count_q;

	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic                key_we;
	logic                data_we;
	logic [KEY_W-1:0]    key_wd;
	logic [DATA_W-1:0]   data_wd;
	logic [KEY_W-1:0]    key_rd;
	logic [DATA_W-1:0]   data_rd;

	logic [CW-1:0]       iter_nxt;
	logic [CW-1:0]       idx_m1;
	logic                scan_issue;
	logic                hit;

	assign iter_nxt   = CW'(iter_pos_q) + CW'(1);
	assign idx_m1     = idx_q - CW'(1);
	assign scan_issue = idx_q < count_q;
	assign hit        = (rank_q < count_q) && (key_rd == key_q);

	assign cmd.ready    = (state_q == S_IDLE);
	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = rsp_status_q;
	assign rsp.found    = rsp_found_q;
	assign rsp.key_out  = rsp_key_q;
	assign rsp.data_out = rsp_data_q;
	assign rsp.count    = rsp_count_q;

	always_comb begin
		rd_addr = '0;
		wr_addr = '0;
		key_we  = 1'b0;
		data_we = 1'b0;
		key_wd  = key_q;
		data_wd = value_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_t'(cmd.command) == CMD_NEXT) begin
					rd_addr = iter_nxt[AW-1:0];
				end
			end
			S_SCAN: begin
				rd_addr = idx_q[AW-1:0];
			end
			S_HIT_RD: begin
				rd_addr = rank_q[AW-1:0];
			end
			S_HIT_CMP: begin
				wr_addr = rank_q[AW-1:0];
				data_we = (cmd_q == CMD_PUT) && hit;
			end
			S_SH_RD: begin
				rd_addr = idx_m1[AW-1:0];
			end
			S_SH_WR: begin
				wr_addr = idx_q[AW-1:0];
				key_we  = 1'b1;
				data_we = 1'b1;
				key_wd  = key_rd;
				data_wd = data_rd;
			end
			S_INS: begin
				wr_addr = rank_q[AW-1:0];
				key_we  = 1'b1;
				data_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	skvt_ram #(
		.WIDTH (KEY_W),
		.DEPTH (CAPACITY)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (wr_addr),
		.wdata (key_wd),
		.raddr (rd_addr),
		.rdata (key_rd)
	);

	skvt_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (wr_addr),
		.wdata (data_wd),
		.raddr (rd_addr),
		.rdata (data_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			signed_keys_q <= 1'b0;
			count_q       <= '0;
			iter_pos_q    <= '0;
			iter_valid_q  <= 1'b0;
			scan_vld_s1   <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				signed_keys_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						cmd_q    <= cmd_t'(cmd.command);
						key_q    <= cmd.key;
						value_q  <= cmd.value;
						status_q <= ST_OK;
						found_q  <= 1'b0;
						kout_q   <= '0;
						dout_q   <= '0;
						case (cmd_t'(cmd.command))
							CMD_PUT, CMD_LOOKUP: begin
								iter_valid_q <= 1'b0;
								idx_q        <= '0;
								rank_q       <= '0;
								scan_vld_s1  <= 1'b0;
								state_q      <= S_SCAN;
							end
							CMD_FIRST: begin
								if (count_q == '0) begin
									status_q     <= ST_MISS;
									iter_valid_q <= 1'b0;
									state_q      <= S_DONE;
								end else begin
									iter_pos_q   <= '0;
									iter_valid_q <= 1'b1;
									state_q      <= S_ITER_RD;
								end
							end
							default: begin
								if (!iter_valid_q || iter_nxt >= count_q) begin
									status_q <= ST_MISS;
									state_q  <= S_DONE;
								end else begin
									iter_pos_q <= iter_nxt[AW-1:0];
									state_q    <= S_ITER_RD;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					scan_vld_s1 <= scan_issue;
					if (scan_issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (scan_vld_s1 && key_less(key_rd, key_q, signed_keys_q)) begin
						rank_q <= rank_q + CW'(1);
					end
					if (!scan_issue && !scan_vld_s1) begin
						state_q <= S_HIT_RD;
					end
				end
				S_HIT_RD: begin
					state_q <= S_HIT_CMP;
				end
				S_HIT_CMP: begin
					if (cmd_q == CMD_LOOKUP) begin
						if (hit) begin
							found_q <= 1'b1;
							dout_q  <= data_rd;
						end else begin
							status_q <= ST_MISS;
						end
						state_q <= S_DONE;
					end else if (hit) begin
						found_q <= 1'b1;
						state_q <= S_DONE;
					end else if (count_q >= CAP_C) begin
						status_q <= ST_FULL;
						state_q  <= S_DONE;
					end else begin
						idx_q   <= count_q;
						state_q <= S_SH_RD;
					end
				end
				S_SH_RD: begin
					if (idx_q > rank_q) begin
						state_q <= S_SH_WR;
					end else begin
						state_q <= S_INS;
					end
				end
				S_SH_WR: begin
					idx_q   <= idx_m1;
					state_q <= S_SH_RD;
				end
				S_INS: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_ITER_RD: begin
					kout_q  <= key_rd;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= status_q;
						rsp_found_q  <= found_q;
						rsp_key_q    <= kout_q;
						rsp_data_q   <= dout_q;
						rsp_count_q  <= COUNT_W'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
